@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the core RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_CLKED(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLKED(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ rtl/core/msc_pkg.sv @@
// ---------------------------------------------------------------------------
// msc_pkg
// Opcode, function codes and defaults of the single-cycle core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package msc_pkg;

  // default data memory depth in words (power of two)
  localparam int unsigned DATA_WORDS_DEF = 128;

  // primary opcodes
  localparam logic [5:0] OPC_RTYPE = 6'b000000;
  localparam logic [5:0] OPC_J     = 6'b000010;
  localparam logic [5:0] OPC_BEQ   = 6'b000100;
  localparam logic [5:0] OPC_BNE   = 6'b000101;
  localparam logic [5:0] OPC_ADDI  = 6'b001000;
  localparam logic [5:0] OPC_SLTI  = 6'b001010;
  localparam logic [5:0] OPC_ANDI  = 6'b001100;
  localparam logic [5:0] OPC_ORI   = 6'b001101;
  localparam logic [5:0] OPC_LW    = 6'b100011;
  localparam logic [5:0] OPC_SW    = 6'b101011;

  // r-type function codes
  localparam logic [5:0] FN_ADD = 6'b100000;
  localparam logic [5:0] FN_SUB = 6'b100010;
  localparam logic [5:0] FN_AND = 6'b100100;
  localparam logic [5:0] FN_OR  = 6'b100101;
  localparam logic [5:0] FN_SLT = 6'b101010;

  // input beat kind carried on tuser
  localparam logic OP_EXEC    = 1'b0;
  localparam logic OP_PRELOAD = 1'b1;

endpackage

@@ rtl/core/mips_single_cycle_core.sv @@
// ---------------------------------------------------------------------------
// mips_single_cycle_core
// MIPS32 subset core: one instruction or data preload per input beat
// ---------------------------------------------------------------------------
// Takes one beat per cycle while not stalled and returns one result beat per
// input beat, in order. A beat is held in the execute stage (register
// operands were read from the register file as it was accepted, the ALU,
// branch and data memory access work there) and then in the result register,
// which drives m_axis; the result of a beat reaches m_axis once the beat has
// moved from the execute stage register into the result register. Throughput
// is one beat per cycle as long as m_axis_tready stays high; a value still
// waiting in the result register is forwarded to the execute stage. After
// reset the data memory is cleared one word per cycle, and s_axis_tready
// stays low meanwhile.
// DATA_WORDS must be a power of two; word addresses wrap at that depth.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mips_single_cycle_core #(
  parameter int unsigned DATA_WORDS = msc_pkg::DATA_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // instr_word [31:0], preload_index [38:32], preload_value [70:39]
  input  logic [71:0] s_axis_tdata,
  // op [0]
  input  logic        s_axis_tuser,
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // next_pc [31:0], reg_written [32], dest_reg [37:33], write_value [69:38],
  // mem_written [70], mem_index [77:71], illegal [78]
  output logic [79:0] m_axis_tdata
);

  import msc_pkg::*;

  localparam int unsigned AW = $clog2(DATA_WORDS);
  localparam logic [29:0] IDX_MASK = 30'(DATA_WORDS - 1);
  localparam logic [AW:0] CLR_END  = (AW + 1)'(DATA_WORDS);

  // storage
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_q;
  logic [31:0] dm_mem [DATA_WORDS];
  logic [31:0] dm_rd_q;

  // control
  logic [AW:0] clr_cnt_q, clr_cnt_d;
  logic        clearing;
  logic        ex_vld_q, ex_vld_d;
  logic        wb_vld_q, wb_vld_d;
  logic [31:0] pc_q, pc_d;
  logic        s_accept, out_fire, wb_free, ex_move;

  // execute stage payload
  logic        ex_op_q;
  logic [31:0] ex_iw_q;
  logic [6:0]  ex_plidx_q;
  logic [31:0] ex_plval_q;
  logic [31:0] ex_rs_q, ex_rt_q;

  // result stage payload
  logic [31:0] wb_npc_q;
  logic        wb_rw_q;
  logic [4:0]  wb_dest_q;
  logic [31:0] wb_wval_q;
  logic        wb_mw_q;
  logic [6:0]  wb_midx_q;
  logic        wb_ill_q;
  logic        wb_lw_q;
  logic [31:0] wb_reg_val;

  // register file write port
  logic        rf_we;
  logic [4:0]  rf_waddr;
  logic [31:0] rf_wdata;

  // data memory write port
  logic          dm_we;
  logic [AW-1:0] dm_waddr;
  logic [31:0]   dm_wdata;

  // execute results
  logic [5:0]  opc, fn;
  logic [4:0]  rs, rt, rd;
  logic [31:0] simm, zimm, op_a, op_b, pc4, addr;
  logic [31:0] x_npc, x_wval;
  logic [29:0] x_midx;
  logic [4:0]  x_dest;
  logic        x_wr, x_rw, x_mw, x_ill, x_lw;

  // handshake and stage flow
  assign clearing      = (clr_cnt_q != CLR_END);
  assign out_fire      = wb_vld_q && m_axis_tready;
  assign wb_free       = !wb_vld_q || m_axis_tready;
  assign ex_move       = ex_vld_q && wb_free;
  assign s_axis_tready = (!ex_vld_q || wb_free) && !clearing;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    ex_vld_d  = ex_vld_q;
    wb_vld_d  = wb_vld_q;
    clr_cnt_d = clr_cnt_q;
    pc_d      = pc_q;
    if (s_accept) begin
      ex_vld_d = 1'b1;
    end else if (ex_move) begin
      ex_vld_d = 1'b0;
    end
    if (ex_move) begin
      wb_vld_d = 1'b1;
    end else if (out_fire) begin
      wb_vld_d = 1'b0;
    end
    if (clearing) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
    end
    if (ex_move && (ex_op_q == OP_EXEC)) begin
      pc_d = x_npc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld_q  <= 1'b0;
      wb_vld_q  <= 1'b0;
      clr_cnt_q <= '0;
      pc_q      <= '0;
    end else begin
      ex_vld_q  <= ex_vld_d;
      wb_vld_q  <= wb_vld_d;
      clr_cnt_q <= clr_cnt_d;
      pc_q      <= pc_d;
    end
  end

  // register value of the beat in the result stage, still to be written
  assign wb_reg_val = wb_lw_q ? dm_rd_q : wb_wval_q;

  // register file writes when a result beat leaves
  assign rf_we    = out_fire && wb_rw_q;
  assign rf_waddr = wb_dest_q;
  assign rf_wdata = wb_reg_val;

  // register file valid bits, an entry never written reads zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else if (rf_we) begin
      rf_vld_q[rf_waddr] <= 1'b1;
    end
  end

  // register file array and operand read on accept, write-first
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
    if (s_accept) begin
      if (rf_we && (rf_waddr == s_axis_tdata[25:21])) begin
        ex_rs_q <= rf_wdata;
      end else begin
        ex_rs_q <= rf_vld_q[s_axis_tdata[25:21]] ? rf_mem[s_axis_tdata[25:21]] : '0;
      end
      if (rf_we && (rf_waddr == s_axis_tdata[20:16])) begin
        ex_rt_q <= rf_wdata;
      end else begin
        ex_rt_q <= rf_vld_q[s_axis_tdata[20:16]] ? rf_mem[s_axis_tdata[20:16]] : '0;
      end
    end
  end

  // execute stage input register
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      ex_op_q    <= s_axis_tuser;
      ex_iw_q    <= s_axis_tdata[31:0];
      ex_plidx_q <= s_axis_tdata[38:32];
      ex_plval_q <= s_axis_tdata[70:39];
    end
  end

  // instruction fields and forwarded operands
  assign opc  = ex_iw_q[31:26];
  assign rs   = ex_iw_q[25:21];
  assign rt   = ex_iw_q[20:16];
  assign rd   = ex_iw_q[15:11];
  assign fn   = ex_iw_q[5:0];
  assign zimm = {16'b0, ex_iw_q[15:0]};
  assign simm = {{16{ex_iw_q[15]}}, ex_iw_q[15:0]};
  assign op_a = (wb_vld_q && wb_rw_q && (wb_dest_q == rs)) ? wb_reg_val : ex_rs_q;
  assign op_b = (wb_vld_q && wb_rw_q && (wb_dest_q == rt)) ? wb_reg_val : ex_rt_q;
  assign pc4  = pc_q + 32'd4;
  assign addr = op_a + simm;

  // decode and execute
  always_comb begin
    x_npc  = pc4;
    x_wval = '0;
    x_midx = '0;
    x_dest = '0;
    x_wr   = 1'b0;
    x_mw   = 1'b0;
    x_ill  = 1'b0;
    x_lw   = 1'b0;
    if (ex_op_q == OP_PRELOAD) begin
      x_npc  = pc_q;
      x_wval = ex_plval_q;
      x_mw   = 1'b1;
      x_midx = {23'b0, ex_plidx_q} & IDX_MASK;
    end else begin
      case (opc)
        OPC_RTYPE: begin
          x_dest = rd;
          x_wr   = 1'b1;
          case (fn)
            FN_ADD:  x_wval = op_a + op_b;
            FN_SUB:  x_wval = op_a - op_b;
            FN_AND:  x_wval = op_a & op_b;
            FN_OR:   x_wval = op_a | op_b;
            FN_SLT:  x_wval = {31'b0, $signed(op_a) < $signed(op_b)};
            default: begin
              x_wr   = 1'b0;
              x_dest = '0;
              x_ill  = 1'b1;
            end
          endcase
        end
        OPC_ADDI: begin
          x_dest = rt;
          x_wr   = 1'b1;
          x_wval = op_a + simm;
        end
        OPC_SLTI: begin
          x_dest = rt;
          x_wr   = 1'b1;
          x_wval = {31'b0, $signed(op_a) < $signed(simm)};
        end
        OPC_ANDI: begin
          x_dest = rt;
          x_wr   = 1'b1;
          x_wval = op_a & zimm;
        end
        OPC_ORI: begin
          x_dest = rt;
          x_wr   = 1'b1;
          x_wval = op_a | zimm;
        end
        OPC_LW: begin
          x_dest = rt;
          x_wr   = 1'b1;
          x_lw   = 1'b1;
          x_midx = addr[31:2] & IDX_MASK;
        end
        OPC_SW: begin
          x_mw   = 1'b1;
          x_wval = op_b;
          x_midx = addr[31:2] & IDX_MASK;
        end
        OPC_BEQ: begin
          if (op_a == op_b) begin
            x_npc = pc4 + {simm[29:0], 2'b00};
          end
        end
        OPC_BNE: begin
          if (op_a != op_b) begin
            x_npc = pc4 + {simm[29:0], 2'b00};
          end
        end
        OPC_J: begin
          x_npc = {pc4[31:28], ex_iw_q[25:0], 2'b00};
        end
        default: begin
          x_ill = 1'b1;
        end
      endcase
    end
  end

  // register zero is never written
  assign x_rw = x_wr && (x_dest != 5'd0);

  // data memory port: clearing pass, then store and preload
  assign dm_we    = clearing || (ex_move && x_mw);
  assign dm_waddr = clearing ? clr_cnt_q[AW-1:0] : x_midx[AW-1:0];
  assign dm_wdata = clearing ? '0 : x_wval;

  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dm_mem[dm_waddr] <= dm_wdata;
    end
    if (ex_move) begin
      dm_rd_q <= dm_mem[x_midx[AW-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ex_move) begin
      wb_npc_q  <= x_npc;
      wb_rw_q   <= x_rw;
      wb_dest_q <= x_dest;
      wb_wval_q <= x_wval;
      wb_mw_q   <= x_mw;
      wb_midx_q <= x_midx[6:0];
      wb_ill_q  <= x_ill;
      wb_lw_q   <= x_lw;
    end
  end

  // result beat
  assign m_axis_tvalid = wb_vld_q;
  assign m_axis_tdata  = {1'b0, wb_ill_q, wb_midx_q, wb_mw_q, wb_reg_val,
                          wb_dest_q, wb_rw_q, wb_npc_q};

  // checks
  `ASSERT_NEVER(a_no_accept_clr, clk_i, rst_ni, clearing && s_axis_tready)
  `ASSERT_NEVER(a_no_r0_write, clk_i, rst_ni, rf_we && (rf_waddr == 5'd0))
  `ASSERT_NEVER(a_ex_needs_room, clk_i, rst_ni, ex_move && wb_vld_q && !m_axis_tready)
  `ASSERT_CLKED(a_pc_hold, clk_i, rst_ni, !ex_move |=> $stable(pc_q))
  `ASSERT_CLKED(a_wb_fill, clk_i, rst_ni, ex_move |=> wb_vld_q)

endmodule
